// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define AST_HOLDS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// expression must never be true out of reset
`define AST_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define AST_HOLDS(label, clk, rst_n, prop)
`define AST_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== src/uer_pkg.sv =====
package uer_pkg;

	localparam int WIDTH_BITS_DEF = 16;
	localparam int TICK_BITS = 21;
	localparam int DIST_BITS = 17;
	localparam int DIST_SHIFT = 16;
	localparam logic [16:0] DIST_MUL = 17'd112412;

	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 21;

	localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_WIDTH = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LISTEN_WINDOW = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_GAP = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_LIMIT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FAR_LIMIT = 3'd4;

	typedef enum logic [1:0] {
		PH_TRIGGER = 2'd0,
		PH_LISTEN = 2'd1,
		PH_IDLE = 2'd2
	} uer_phase_t;

	typedef struct packed {
		logic [7:0] trigger_width;
		logic [19:0] listen_window;
		logic [20:0] idle_gap;
		logic [15:0] near_limit;
		logic [15:0] far_limit;
	} uer_cfg_t;

	// per-tick control out of the sequencer
	typedef struct packed {
		logic trig;
		logic report;
	} uer_eval_t;

endpackage

// ===== src/ultrasonic_echo_ranger.sv =====
// Ultrasonic ranger controller. Each sample request is one microsecond tick carrying the
// echo pin level, and each gives exactly one report request with the trigger pin level for
// that tick plus, on the last tick of the listen window, the measured distance or the
// out-of-range flag. One sample is taken every clock unless stalled: the sequencer state
// updates in the cycle the sample is accepted and the distance multiply lands in a single
// output register, so the report appears in the next cycle. When that register is full and
// stalled, the sample side stalls too. Configuration writes are always ready and registered.
`include "assert_macros.svh"

module ultrasonic_echo_ranger #(
	parameter int WIDTH_BITS = uer_pkg::WIDTH_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	input  logic echo_level,
	output logic report_valid,
	input  logic report_stall,
	output logic trigger_level,
	output logic result_valid,
	output logic [uer_pkg::DIST_BITS-1:0] distance_centi_cm,
	output logic out_of_range,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [uer_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [uer_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	uer_pkg::uer_cfg_t cfg;
	uer_pkg::uer_eval_t eval;
	logic [WIDTH_BITS-1:0] width;
	logic accept;

	assign cfg_ready = 1'b1;
	assign sample_stall = report_valid && report_stall;
	assign accept = sample_valid && !sample_stall;

	uer_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	uer_timer #(.WIDTH_BITS(WIDTH_BITS)) u_timer (
		.clk(clk),
		.arst_n(arst_n),
		.advance(accept),
		.echo_level(echo_level),
		.cfg(cfg),
		.eval(eval),
		.width(width)
	);

	uer_report #(.WIDTH_BITS(WIDTH_BITS)) u_report (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept),
		.eval(eval),
		.width(width),
		.near_limit(cfg.near_limit),
		.far_limit(cfg.far_limit),
		.report_stall(report_stall),
		.report_valid(report_valid),
		.trigger_level(trigger_level),
		.result_valid(result_valid),
		.distance_centi_cm(distance_centi_cm),
		.out_of_range(out_of_range)
	);

	// a measurement is never reported during the trigger pulse
	`AST_NEVER(a_report_not_in_trigger, clk, arst_n, eval.trig && eval.report)
	// out of range always reads as zero distance
	`AST_HOLDS(a_oor_zero_dist, clk, arst_n,
		(report_valid && out_of_range) |-> (distance_centi_cm == '0))
	// no flag and no distance on ticks without a measurement
	`AST_HOLDS(a_idle_fields_clear, clk, arst_n,
		(report_valid && !result_valid) |-> (!out_of_range && distance_centi_cm == '0))
	// an accepted sample always fills the report register
	`AST_HOLDS(a_accept_fills, clk, arst_n, accept |=> report_valid)

endmodule

// ===== src/uer_cfg.sv =====
module uer_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic [uer_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [uer_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output uer_pkg::uer_cfg_t cfg
);

	uer_pkg::uer_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_width <= 8'd10;
			cfg_q.listen_window <= 20'd60000;
			cfg_q.idle_gap <= 21'd1000000;
			cfg_q.near_limit <= 16'd116;
			cfg_q.far_limit <= 16'd23200;
		end else if (cfg_valid) begin
			case (cfg_index)
				uer_pkg::CFG_TRIGGER_WIDTH: cfg_q.trigger_width <= cfg_data[7:0];
				uer_pkg::CFG_LISTEN_WINDOW: cfg_q.listen_window <= cfg_data[19:0];
				uer_pkg::CFG_IDLE_GAP: cfg_q.idle_gap <= cfg_data[20:0];
				uer_pkg::CFG_NEAR_LIMIT: cfg_q.near_limit <= cfg_data[15:0];
				uer_pkg::CFG_FAR_LIMIT: cfg_q.far_limit <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/uer_timer.sv =====
module uer_timer #(
	parameter int WIDTH_BITS = uer_pkg::WIDTH_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic echo_level,
	input  uer_pkg::uer_cfg_t cfg,
	output uer_pkg::uer_eval_t eval,
	output logic [WIDTH_BITS-1:0] width
);

	localparam int TB = uer_pkg::TICK_BITS;

	uer_pkg::uer_phase_t phase_q, phase_d;
	logic [TB-1:0] ticks_q, ticks_d;
	logic [TB:0] ticks_inc;
	logic echo_prev_q;
	logic [WIDTH_BITS-1:0] cnt_q, cnt_d;
	logic [WIDTH_BITS-1:0] meas_q, meas_d;
	logic [7:0] trig_len;
	logic [19:0] listen_len;

	// zero lengths behave as one tick
	assign trig_len = (cfg.trigger_width == 8'd0) ? 8'd1 : cfg.trigger_width;
	assign listen_len = (cfg.listen_window == 20'd0) ? 20'd1 : cfg.listen_window;
	// one bit wider so the compare sees the carry before the wrap
	assign ticks_inc = {1'b0, ticks_q} + {{TB{1'b0}}, 1'b1};

	always_comb begin
		phase_d = phase_q;
		ticks_d = ticks_q;
		cnt_d = cnt_q;
		meas_d = meas_q;
		eval = '0;
		case (phase_q)
			uer_pkg::PH_LISTEN: begin
				if (echo_level) begin
					if (!echo_prev_q) begin
						cnt_d = WIDTH_BITS'(1);
					end else if (cnt_q != {WIDTH_BITS{1'b1}}) begin
						cnt_d = cnt_q + WIDTH_BITS'(1);
					end
				end else if (echo_prev_q) begin
					meas_d = cnt_q;
				end
				ticks_d = ticks_inc[TB-1:0];
				if (ticks_inc >= {2'b00, listen_len}) begin
					eval.report = 1'b1;
					ticks_d = '0;
					phase_d = (cfg.idle_gap == 21'd0) ? uer_pkg::PH_TRIGGER : uer_pkg::PH_IDLE;
				end
			end
			uer_pkg::PH_IDLE: begin
				ticks_d = ticks_inc[TB-1:0];
				if (ticks_inc >= {1'b0, cfg.idle_gap}) begin
					ticks_d = '0;
					phase_d = uer_pkg::PH_TRIGGER;
				end
			end
			default: begin
				// fresh measurement on the first trigger tick
				if (ticks_q == '0) begin
					cnt_d = '0;
					meas_d = '0;
				end
				eval.trig = 1'b1;
				ticks_d = ticks_inc[TB-1:0];
				if (ticks_inc >= {14'd0, trig_len}) begin
					ticks_d = '0;
					phase_d = uer_pkg::PH_LISTEN;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uer_pkg::PH_TRIGGER;
			ticks_q <= '0;
			echo_prev_q <= 1'b0;
			cnt_q <= '0;
			meas_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			echo_prev_q <= echo_level;
			cnt_q <= cnt_d;
			meas_q <= meas_d;
		end
	end

	assign width = meas_d;

endmodule

// ===== src/uer_report.sv =====
module uer_report #(
	parameter int WIDTH_BITS = uer_pkg::WIDTH_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  uer_pkg::uer_eval_t eval,
	input  logic [WIDTH_BITS-1:0] width,
	input  logic [15:0] near_limit,
	input  logic [15:0] far_limit,
	input  logic report_stall,
	output logic report_valid,
	output logic trigger_level,
	output logic result_valid,
	output logic [uer_pkg::DIST_BITS-1:0] distance_centi_cm,
	output logic out_of_range
);

	localparam int CW = (WIDTH_BITS > 16) ? WIDTH_BITS : 16;
	localparam int PW = (WIDTH_BITS + 17 > uer_pkg::DIST_SHIFT + uer_pkg::DIST_BITS)
		? WIDTH_BITS + 17 : uer_pkg::DIST_SHIFT + uer_pkg::DIST_BITS;

	logic [CW-1:0] width_c, short_c, long_c;
	logic in_range;
	logic [PW-1:0] product;
	logic valid_q;
	logic trig_q, rv_q, oor_q;
	logic [uer_pkg::DIST_BITS-1:0] dist_q;

	assign width_c = CW'(width);
	assign short_c = CW'(near_limit);
	assign long_c = CW'(far_limit);
	assign in_range = (width_c > short_c) && (width_c < long_c);
	// width * 100 / 58.3 in fixed point, factor with 16 fractional bits
	assign product = PW'(width) * PW'(uer_pkg::DIST_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!report_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			trig_q <= eval.trig;
			rv_q <= eval.report;
			oor_q <= eval.report && !in_range;
			dist_q <= (eval.report && in_range)
				? product[uer_pkg::DIST_SHIFT +: uer_pkg::DIST_BITS] : '0;
		end
	end

	assign report_valid = valid_q;
	assign trigger_level = trig_q;
	assign result_valid = rv_q;
	assign distance_centi_cm = dist_q;
	assign out_of_range = oor_q;

endmodule
